// File: hw/rtl/counting_semaphore_fifo_waiters_top_defines.svh
// Assertion macros for the counting semaphore block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_TOP_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define CSFW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define CSFW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/csfw_pkg.sv
// Shared types and constants of the counting semaphore block.
// No dependencies; used by the controller, datapath and top level.
package csfw_pkg;

  // Operation codes
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_DOWN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UP      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

  // Status codes
  localparam int STS_W = 2;
  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_INACTIVE = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY    = 2'd2;
  localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd3;

  // Count range
  localparam int CNT_W = 16;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

  // Controller to datapath
  typedef struct packed {
    logic latch;  // capture the accepted transaction
    logic exec;   // execute one step and load the output register
  } csfw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;   // this step produces the final result of the transaction
  } csfw_sts_t;

endpackage

// File: hw/rtl/counting_semaphore_fifo_waiters_top.sv
// Top level of the counting semaphore with a FIFO of blocked task ids.
// Depends on csfw_pkg, csfw_ctrl, csfw_dp, csfw_ram and the assertion header.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+--------------------------------------
//   in       | input     | in_valid_i / in_stall_o  | mode_i, task_id_i
//   out      | output    | out_valid_o / out_stall_i| status_o, caller_blocked_o,
//            |           |                          | woken_valid_o, woken_task_o, last_o
//   cfg      | input     | cfg_we_i                 | cfg_wdata_i (initial count)
//
// Down, up and no-op run as an accept, then one execute step with the queue RAM.
// Destroy: accept, then one step per waiter (min. one); the single RAM read port drains one
// per unstalled cycle. Output stall holds the execute step; a result waits in the output register.
// Reset needs no clearing pass: the fill count tracks which queue entries are live.
`include "counting_semaphore_fifo_waiters_top_defines.svh"

module counting_semaphore_fifo_waiters_top #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic signed [csfw_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [csfw_pkg::MODE_W-1:0]        mode_i,
  input  logic [TASK_ID_BITS-1:0]            task_id_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [csfw_pkg::STS_W-1:0]         status_o,
  output logic                               caller_blocked_o,
  output logic                               woken_valid_o,
  output logic [TASK_ID_BITS-1:0]            woken_task_o,
  output logic                               last_o
);
  import csfw_pkg::*;

  csfw_cmd_t cmd;
  csfw_sts_t sts;

  csfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  csfw_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mode_i           (mode_i),
    .task_id_i        (task_id_i),
    .status_o         (status_o),
    .caller_blocked_o (caller_blocked_o),
    .woken_valid_o    (woken_valid_o),
    .woken_task_o     (woken_task_o),
    .last_o           (last_o)
  );

  // An accepted transaction keeps the input side busy for the execute step
  `CSFW_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after accept")

  // Only a destroy drain gives more than one result, and each carries a woken id
  `CSFW_ASSERT_IMP(a_nonlast_is_drain, out_valid_o && !last_o, woken_valid_o && (status_o == STS_OK), "non-final result without woken id")

  // A blocked caller never comes with a woken id or an error
  `CSFW_ASSERT_IMP(a_blocked_clean, out_valid_o && caller_blocked_o, !woken_valid_o && (status_o == STS_OK), "blocked result carries wake or error")

  // A step only runs while the output register can take its result
  `CSFW_ASSERT_IMP(a_exec_has_room, cmd.exec, !out_valid_o || !out_stall_i, "step while result stalled")

endmodule

// File: hw/rtl/csfw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/csfw_ctrl.sv
// Controller of the counting semaphore: input/output handshakes and step sequencing.
// Depends on csfw_pkg.
module csfw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output csfw_pkg::csfw_cmd_t  cmd_o,
  input  csfw_pkg::csfw_sts_t  sts_i
);
  import csfw_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;

  // Handshake decode
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign cmd_o.latch = accept;
  assign cmd_o.exec  = (state_q == S_EXEC) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.exec && sts_i.last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on a step, held while stalled
  always_comb begin
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_stall_i) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/csfw_dp.sv
// Datapath of the counting semaphore: count, active flag, waiter queue, result register.
// Depends on csfw_pkg and csfw_ram.
module csfw_dp #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csfw_pkg::csfw_cmd_t                 cmd_i,
  output csfw_pkg::csfw_sts_t                 sts_o,
  input  logic                                cfg_we_i,
  input  logic signed [csfw_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic [csfw_pkg::MODE_W-1:0]         mode_i,
  input  logic [TASK_ID_BITS-1:0]             task_id_i,
  output logic [csfw_pkg::STS_W-1:0]          status_o,
  output logic                                caller_blocked_o,
  output logic                                woken_valid_o,
  output logic [TASK_ID_BITS-1:0]             woken_task_o,
  output logic                                last_o
);
  import csfw_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  // Latched transaction
  logic [MODE_W-1:0]       mode_q;
  logic [TASK_ID_BITS-1:0] tid_q;

  // Semaphore state
  logic signed [CNT_W-1:0] count_q, count_d;
  logic                    active_q, active_d;
  logic [PTR_W-1:0]        head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]       fill_q, fill_d;

  // Result register
  logic [STS_W-1:0]        status_q, status_d;
  logic                    blocked_q, blocked_d;
  logic                    wvalid_q, wvalid_d;
  logic [TASK_ID_BITS-1:0] wtask_q, wtask_d;
  logic                    last_q, last_d;

  logic signed [CNT_W-1:0] cnt_dec, cnt_inc;
  logic [PTR_W-1:0]        head_inc, tail_inc;
  logic                    fill_zero, fill_one, fill_full;
  logic                    push, pop;
  logic [PTR_W-1:0]        raddr;
  logic [TASK_ID_BITS-1:0] rdata;

  // Saturating count steps
  assign cnt_dec = (count_q == CNT_MIN) ? CNT_MIN : count_q - 16'sd1;
  assign cnt_inc = (count_q == CNT_MAX) ? CNT_MAX : count_q + 16'sd1;

  // Queue pointers and fill flags
  assign head_inc  = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc  = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign fill_zero = (fill_q == '0);
  assign fill_one  = (fill_q == FILL_W'(1));
  assign fill_full = (fill_q == FILL_W'(QUEUE_DEPTH));

  // Operation decode: one result per step
  always_comb begin
    count_d   = count_q;
    active_d  = active_q;
    push      = 1'b0;
    pop       = 1'b0;
    status_d  = STS_OK;
    blocked_d = 1'b0;
    wvalid_d  = 1'b0;
    wtask_d   = '0;
    last_d    = 1'b1;
    case (mode_q)
      MODE_DESTROY: begin
        active_d = 1'b0;
        if (!fill_zero) begin
          pop      = 1'b1;
          wvalid_d = 1'b1;
          wtask_d  = rdata;
          last_d   = fill_one;
        end
      end
      MODE_DOWN: begin
        if (!active_q) begin
          status_d = STS_INACTIVE;
        end else if (cnt_dec[CNT_W-1]) begin
          if (fill_full) begin
            status_d = STS_OVERFLOW;
          end else begin
            push      = 1'b1;
            count_d   = cnt_dec;
            blocked_d = 1'b1;
          end
        end else begin
          count_d = cnt_dec;
        end
      end
      MODE_UP: begin
        if (!active_q) begin
          status_d = STS_INACTIVE;
        end else begin
          count_d = cnt_inc;
          if (cnt_inc[CNT_W-1] || (cnt_inc == '0)) begin
            if (fill_zero) begin
              status_d = STS_EMPTY;
            end else begin
              pop      = 1'b1;
              wvalid_d = 1'b1;
              wtask_d  = rdata;
            end
          end
        end
      end
      MODE_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Queue bookkeeping
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (push) begin
      tail_d = tail_inc;
      fill_d = fill_q + 1'b1;
    end else if (pop) begin
      head_d = head_inc;
      fill_d = fill_q - 1'b1;
    end
  end

  // Read ahead to the next head when popping, so a drain runs one per cycle while not stalled
  assign raddr = (cmd_i.exec && pop) ? head_inc : head_q;

  csfw_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && push),
    .waddr_i (tail_q),
    .wdata_i (tid_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control state; a config write re-creates the semaphore
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      active_q <= 1'b1;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
    end else if (cfg_we_i) begin
      count_q  <= cfg_wdata_i;
      active_q <= 1'b1;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
    end else if (cmd_i.exec) begin
      count_q  <= count_d;
      active_q <= active_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
    end
  end

  // Transaction capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      tid_q  <= task_id_i;
    end
    if (cmd_i.exec) begin
      status_q  <= status_d;
      blocked_q <= blocked_d;
      wvalid_q  <= wvalid_d;
      wtask_q   <= wtask_d;
      last_q    <= last_d;
    end
  end

  assign sts_o.last       = last_d;
  assign status_o         = status_q;
  assign caller_blocked_o = blocked_q;
  assign woken_valid_o    = wvalid_q;
  assign woken_task_o     = wtask_q;
  assign last_o           = last_q;

endmodule

// File: tb/counting_semaphore_fifo_waiters_top_test.sv
// Testbench for the counting semaphore with a FIFO of blocked task ids.
// Needs csfw_pkg and counting_semaphore_fifo_waiters_top; a local semaphore model predicts
// every result transaction, and a monitor checks each one as the block hands it out.
module counting_semaphore_fifo_waiters_top_test;
  import csfw_pkg::*;

  localparam int QUEUE_DEPTH     = 16;
  localparam int TASK_ID_BITS    = 8;
  localparam int CYCLE_LIMIT     = 250000;
  localparam int HOLD_OFF_CYCLES = 300;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic                    blocked;
    logic                    woken_valid;
    logic [TASK_ID_BITS-1:0] woken_task;
    logic                    last;
  } sem_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic signed [CNT_W-1:0]  cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [MODE_W-1:0]        mode_i;
  logic [TASK_ID_BITS-1:0]  task_id_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [STS_W-1:0]         status_o;
  logic                     caller_blocked_o;
  logic                     woken_valid_o;
  logic [TASK_ID_BITS-1:0]  woken_task_o;
  logic                     last_o;

  // Semaphore model state
  logic signed [CNT_W-1:0]  model_count = '0;
  logic                     sem_active = 1'b1;
  logic [TASK_ID_BITS-1:0]  sem_waiters[$];
  sem_result_t              pending_results[$];

  int mismatch_count    = 0;
  int cycle_count       = 0;
  int ops_sent          = 0;
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_off_left     = 0;

  counting_semaphore_fifo_waiters_top #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .task_id_i        (task_id_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .caller_blocked_o (caller_blocked_o),
    .woken_valid_o    (woken_valid_o),
    .woken_task_o     (woken_task_o),
    .last_o           (last_o)
  );

  always #4 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch in %s: expected %0d, got %0d (cycle %0d)", what, want, got,
             cycle_count);
    mismatch_count++;
  endtask

  // Work out the results of one accepted transaction and advance the model
  task automatic predict_semaphore(input logic [MODE_W-1:0] op,
                                   input logic [TASK_ID_BITS-1:0] id);
    sem_result_t             res;
    logic signed [CNT_W-1:0] next_count;
    res      = '0;
    res.last = 1'b1;
    case (op)
      MODE_DESTROY: begin
        sem_active = 1'b0;
        if (sem_waiters.size() == 0) pending_results.push_back(res);
        // release waiters oldest first
        while (sem_waiters.size() != 0) begin
          res.woken_valid = 1'b1;
          res.woken_task  = sem_waiters.pop_front();
          res.last        = (sem_waiters.size() == 0);
          pending_results.push_back(res);
        end
      end
      MODE_NOP: pending_results.push_back(res);
      default: begin
        if (!sem_active) begin
          res.status = STS_INACTIVE;
        end else if (op == MODE_DOWN) begin
          next_count = (model_count == CNT_MIN) ? CNT_MIN : model_count - 16'sd1;
          if (next_count < 0) begin
            if (sem_waiters.size() >= QUEUE_DEPTH) begin
              res.status = STS_OVERFLOW;  // count stays put
            end else begin
              sem_waiters.push_back(id);
              model_count = next_count;
              res.blocked = 1'b1;
            end
          end else begin
            model_count = next_count;
          end
        end else begin
          model_count = (model_count == CNT_MAX) ? CNT_MAX : model_count + 16'sd1;
          if (model_count <= 0) begin
            if (sem_waiters.size() == 0) begin
              res.status = STS_EMPTY;  // increment is kept
            end else begin
              res.woken_valid = 1'b1;
              res.woken_task  = sem_waiters.pop_front();
            end
          end
        end
        pending_results.push_back(res);
      end
    endcase
  endtask

  // Output monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    sem_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (status_o != want.status)
          report_mismatch("status", int'(want.status), int'(status_o));
        if (caller_blocked_o != want.blocked)
          report_mismatch("caller_blocked", int'(want.blocked), int'(caller_blocked_o));
        if (woken_valid_o != want.woken_valid)
          report_mismatch("woken_valid", int'(want.woken_valid), int'(woken_valid_o));
        if (woken_task_o != want.woken_task)
          report_mismatch("woken_task", int'(want.woken_task), int'(woken_task_o));
        if (last_o != want.last) report_mismatch("last", int'(want.last), int'(last_o));
      end
    end
  end

  // Output stall: long hold-off when requested, otherwise random idling
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Offer one transaction, wait for acceptance; valid stays high on return
  task automatic issue_op(input logic [MODE_W-1:0] op, input logic [TASK_ID_BITS-1:0] id);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= op;
    task_id_i  <= id;
    do @(posedge clk_i); while (in_stall_o);
    predict_semaphore(op, id);
    if (op != MODE_NOP) ops_sent++;
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Re-create the semaphore; only done with the block idle
  task automatic write_initial_count(input logic signed [CNT_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_count = value;
    sem_active  = 1'b1;
    sem_waiters.delete();
  endtask

  function automatic logic signed [CNT_W-1:0] random_initial_count();
    case ($urandom_range(9))
      0:       return CNT_MAX;
      1:       return CNT_MIN;
      2:       return CNT_W'($urandom_range(65535));
      default: return CNT_W'($urandom_range(10) - 5);
    endcase
  endfunction

  // Extremes, every operation, saturation, empty-queue up, inactive errors
  task automatic test_directed();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    write_initial_count(16'sd0);
    issue_op(MODE_NOP, 8'hA5);
    issue_op(MODE_DOWN, 8'hFF);      // blocks, count -1
    issue_op(MODE_DOWN, 8'h00);      // blocks, count -2
    issue_op(MODE_UP, 8'h12);        // wakes 8'hFF
    issue_op(MODE_UP, 8'h34);        // wakes 8'h00
    issue_op(MODE_UP, 8'h56);        // count 1, nobody to wake
    issue_op(MODE_DOWN, 8'h78);      // back to zero, no block
    issue_op(MODE_DESTROY, 8'h9A);   // empty queue
    issue_op(MODE_DOWN, 8'hBC);      // inactive
    issue_op(MODE_UP, 8'hDE);        // inactive
    issue_op(MODE_DESTROY, 8'hF0);   // destroy again while inactive
    write_initial_count(CNT_MAX);
    issue_op(MODE_UP, 8'h01);        // saturates high
    write_initial_count(CNT_MIN);
    issue_op(MODE_DOWN, 8'h5A);      // saturates low and blocks
    issue_op(MODE_UP, 8'hA5);        // wakes 8'h5A
    write_initial_count(-16'sd5);
    issue_op(MODE_UP, 8'h0F);        // wake wanted, queue empty
    issue_op(MODE_DOWN, 8'hC3);      // blocks
    issue_op(MODE_DESTROY, 8'h3C);   // releases one waiter
  endtask

  // Fill the queue behind a long output stall, overflow it, drain with destroy
  task automatic test_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    write_initial_count(16'sd0);
    hold_off_left = HOLD_OFF_CYCLES;
    for (int i = 0; i <= QUEUE_DEPTH; i++) issue_op(MODE_DOWN, 8'(i * 13 + 7));
    issue_op(MODE_DESTROY, 8'h00);
    issue_op(MODE_UP, 8'h11);
    wait_drained();
    write_initial_count(-16'sd3);
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (6) issue_op(MODE_DOWN, TASK_ID_BITS'($urandom_range(255)));
    repeat (8) issue_op(MODE_UP, TASK_ID_BITS'($urandom_range(255)));
    wait_drained();
  endtask

  // Mostly down bursts followed by ups, mixed with destroys, re-creates and noise
  task automatic test_random_traffic(input int n_ops, input int snd_pct, input int rcv_pct);
    int target;
    int kind;
    int burst;
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    write_initial_count(random_initial_count());
    target = ops_sent + n_ops;
    while (ops_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        burst = $urandom_range(1, 18);
        repeat (burst) issue_op(MODE_DOWN, TASK_ID_BITS'($urandom_range(255)));
        repeat ($urandom_range(1, burst + 2))
          issue_op(MODE_UP, TASK_ID_BITS'($urandom_range(255)));
        if ($urandom_range(4) == 0) begin
          issue_op(MODE_DESTROY, TASK_ID_BITS'($urandom_range(255)));
          write_initial_count(random_initial_count());
        end
      end else if (kind < 66) begin
        issue_op(MODE_DESTROY, TASK_ID_BITS'($urandom_range(255)));
        if ($urandom_range(1) == 0) write_initial_count(random_initial_count());
      end else if (kind < 74) begin
        issue_op(MODE_NOP, TASK_ID_BITS'($urandom_range(255)));
      end else if (kind < 80) begin
        write_initial_count(random_initial_count());
      end else begin
        issue_op(MODE_W'($urandom_range(3)), TASK_ID_BITS'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_NOP;
    task_id_i   = '0;
    out_stall_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random_traffic(120, 17, 55);
    test_random_traffic(120, 55, 17);
    test_random_traffic(120, 0, 0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
